FILE: rtl/bfpa_pkg.sv
`timescale 1ns / 1ps
package bfpa_pkg;

  localparam int OP_W    = 2;
  localparam int JOB_W   = 8;
  localparam int AMT_W   = 16;
  localparam int IDX_W   = 4;
  localparam int STAT_W  = 3;
  localparam int ADDR_W  = 16;
  localparam int TOTAL_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_APP,
    S_RD_START,
    S_RD_MEM,
    S_RD_USE,
    S_AL_START,
    S_AL_SCAN,
    S_AL_USE,
    S_AL_DECIDE,
    S_AL_SHCHK,
    S_AL_SHUSE,
    S_AL_REM,
    S_AL_FRONT,
    S_RL_SCAN,
    S_RL_USE,
    S_RL_NXT,
    S_RL_NMEM,
    S_RL_NUSE,
    S_RL_D1CHK,
    S_RL_D1USE,
    S_RL_PRV,
    S_RL_PMEM,
    S_RL_PUSE,
    S_RL_D2CHK,
    S_RL_D2USE,
    S_RL_WR,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC,
    PTR_IDX,
    PTR_CNT_M1,
    PTR_POS_P1,
    PTR_POS_M1
  } ptr_op_t;

  typedef enum logic [2:0] {
    WA_PTR_P1,
    WA_PTR_M1,
    WA_POS,
    WA_POS_P1,
    WA_CNT
  } wa_sel_t;

  typedef enum logic [2:0] {
    WD_COPY,
    WD_APPEND,
    WD_FRONT,
    WD_REMAIN,
    WD_FREE
  } wd_sel_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_RDATA,
    CUR_APPEND,
    CUR_FRONT,
    CUR_FREE,
    CUR_ADD_NEXT,
    CUR_ADD_PREV
  } cur_op_t;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_PTR,
    POS_DEC
  } pos_op_t;

  typedef struct packed {
    logic    load;
    ptr_op_t ptr_op;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    cur_op_t cur_op;
    pos_op_t pos_op;
    logic    found_clr;
    logic    found_set;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    end_adv;
    logic    out_load;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    logic amt_zero;
    logic full;
    logic overflow;
    logic ptr_at_cnt;
    logic ptr_at_pos;
    logic pos_last;
    logic pos_zero;
    logic idx_bad;
    logic found;
    logic cand;
    logic match;
    logic exact;
    logic adj_next;
    logic adj_prev;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/bfpa_req_if.sv
`timescale 1ns / 1ps
interface bfpa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  job_id;
  logic [15:0] amount;
  logic [3:0]  entry_index;

  modport source (output valid, operation, job_id, amount, entry_index, input ready);
  modport sink (input valid, operation, job_id, amount, entry_index, output ready);
endinterface

FILE: rtl/bfpa_rsp_if.sv
`timescale 1ns / 1ps
interface bfpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] address;
  logic [15:0] part_size;
  logic        is_allocated;
  logic [7:0]  owner_job;
  logic [15:0] requested;
  logic [4:0]  entry_total;

  modport source (output valid, status, address, part_size, is_allocated, owner_job,
                  requested, entry_total, input ready);
  modport sink (input valid, status, address, part_size, is_allocated, owner_job,
                requested, entry_total, output ready);
endinterface

FILE: rtl/bfpa_dpath.sv
`timescale 1ns / 1ps
module bfpa_dpath #(
  parameter int N  = 16,
  parameter int AW = 16,
  parameter int JB = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bfpa_pkg::cmd_t                     cmd,
  output bfpa_pkg::stat_t                    stat,
  input  logic [bfpa_pkg::JOB_W-1:0]         job_id,
  input  logic [bfpa_pkg::AMT_W-1:0]         amount,
  input  logic [bfpa_pkg::IDX_W-1:0]         entry_index,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [bfpa_pkg::STAT_W-1:0]        status,
  output logic [bfpa_pkg::ADDR_W-1:0]        address,
  output logic [bfpa_pkg::ADDR_W-1:0]        part_size,
  output logic                               is_allocated,
  output logic [bfpa_pkg::JOB_W-1:0]         owner_job,
  output logic [bfpa_pkg::AMT_W-1:0]         requested,
  output logic [bfpa_pkg::TOTAL_W-1:0]       entry_total
);
  import bfpa_pkg::*;

  localparam int IW   = $clog2(N);
  localparam int CNTW = $clog2(N + 1);
  localparam int CW   = (AW > AMT_W) ? AW : AMT_W;
  localparam int XW   = (CNTW > IDX_W) ? CNTW : IDX_W;
  localparam logic [CW:0] ADDR_MAX = (CW + 1)'({AW{1'b1}});

  typedef struct packed {
    logic [AW-1:0]    start;
    logic [AW-1:0]    len;
    logic             busy;
    logic [JB-1:0]    owner;
    logic [AMT_W-1:0] req;
  } entry_t;

  entry_t           mem [N];
  entry_t           rdata;
  entry_t           cur;
  entry_t           wdata;
  entry_t           front_e;
  entry_t           remain_e;
  entry_t           append_e;
  entry_t           free_e;
  logic [AMT_W-1:0] amt_q;
  logic [JB-1:0]    job_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNTW-1:0]  ptr;
  logic [IW-1:0]    pos;
  logic [CNTW-1:0]  count;
  logic [AW-1:0]    end_addr;
  logic             found;
  logic [IW-1:0]    wa;
  logic [CNTW-1:0]  ptr_p1;
  logic [CNTW-1:0]  ptr_m1;
  logic [CNTW-1:0]  pos_p1;
  logic [AW-1:0]    amt_aw;
  logic [AW-1:0]    cur_end;
  logic [AW-1:0]    rd_end;

  assign amt_aw  = AW'(amt_q);
  assign cur_end = cur.start + cur.len;
  assign rd_end  = rdata.start + rdata.len;
  assign ptr_p1  = ptr + CNTW'(1);
  assign ptr_m1  = ptr - CNTW'(1);
  assign pos_p1  = CNTW'(pos) + CNTW'(1);

  always_comb begin
    stat.amt_zero   = (amt_q == '0);
    stat.full       = (count == CNTW'(N));
    stat.overflow   = ((CW + 1)'(end_addr) + (CW + 1)'(amt_q)) > ADDR_MAX;
    stat.ptr_at_cnt = (ptr == count);
    stat.ptr_at_pos = (ptr == CNTW'(pos));
    stat.pos_last   = (pos_p1 == count);
    stat.pos_zero   = (pos == '0);
    stat.idx_bad    = (XW'(idx_q) >= XW'(count));
    stat.found      = found;
    stat.cand       = !rdata.busy && (CW'(rdata.len) >= CW'(amt_q)) &&
                      (!found || (rdata.len < cur.len));
    stat.match      = rdata.busy && (rdata.owner == job_q);
    stat.exact      = (CW'(cur.len) == CW'(amt_q));
    stat.adj_next   = !rdata.busy && (cur_end == rdata.start);
    stat.adj_prev   = !rdata.busy && (rd_end == cur.start);
    stat.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    front_e        = cur;
    front_e.len    = amt_aw;
    front_e.busy   = 1'b1;
    front_e.owner  = job_q;
    front_e.req    = amt_q;
    remain_e       = '0;
    remain_e.start = cur.start + amt_aw;
    remain_e.len   = cur.len - amt_aw;
    append_e       = '0;
    append_e.start = end_addr;
    append_e.len   = amt_aw;
    free_e         = '0;
    free_e.start   = cur.start;
    free_e.len     = cur.len;
  end

  always_comb begin
    unique case (cmd.wd_sel)
      WD_COPY:   wdata = rdata;
      WD_APPEND: wdata = append_e;
      WD_FRONT:  wdata = front_e;
      WD_REMAIN: wdata = remain_e;
      WD_FREE:   wdata = free_e;
      default:   wdata = rdata;
    endcase
  end

  always_comb begin
    unique case (cmd.wa_sel)
      WA_PTR_P1: wa = ptr_p1[IW-1:0];
      WA_PTR_M1: wa = ptr_m1[IW-1:0];
      WA_POS:    wa = pos;
      WA_POS_P1: wa = pos_p1[IW-1:0];
      WA_CNT:    wa = count[IW-1:0];
      default:   wa = pos;
    endcase
  end

  // table with a write port at wa and a registered read port at ptr: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wa] <= wdata;
    end
    rdata <= mem[ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      amt_q <= amount;
      job_q <= JB'(job_id);
      idx_q <= entry_index;
    end
    unique case (cmd.cur_op)
      CUR_HOLD:     cur <= cur;
      CUR_RDATA:    cur <= rdata;
      CUR_APPEND:   cur <= append_e;
      CUR_FRONT:    cur <= front_e;
      CUR_FREE:     cur <= free_e;
      CUR_ADD_NEXT: cur.len <= cur.len + rdata.len;
      CUR_ADD_PREV: begin
        cur.start <= rdata.start;
        cur.len   <= rdata.len + cur.len;
      end
      default:      cur <= cur;
    endcase
    unique case (cmd.pos_op)
      POS_HOLD: pos <= pos;
      POS_PTR:  pos <= ptr[IW-1:0];
      POS_DEC:  pos <= pos - IW'(1);
      default:  pos <= pos;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      count    <= '0;
      end_addr <= '0;
      found    <= 1'b0;
    end else begin
      unique case (cmd.ptr_op)
        PTR_HOLD:   ptr <= ptr;
        PTR_ZERO:   ptr <= '0;
        PTR_INC:    ptr <= ptr_p1;
        PTR_DEC:    ptr <= ptr_m1;
        PTR_IDX:    ptr <= CNTW'(idx_q);
        PTR_CNT_M1: ptr <= count - CNTW'(1);
        PTR_POS_P1: ptr <= pos_p1;
        PTR_POS_M1: ptr <= CNTW'(pos) - CNTW'(1);
        default:    ptr <= ptr;
      endcase
      if (cmd.cnt_inc) begin
        count <= count + CNTW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CNTW'(1);
      end
      if (cmd.end_adv) begin
        end_addr <= end_addr + amt_aw;
      end
      if (cmd.found_clr) begin
        found <= 1'b0;
      end else if (cmd.found_set) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= cmd.out_status;
      entry_total <= TOTAL_W'(count);
      if (cmd.out_status == ST_OK) begin
        address      <= ADDR_W'(cur.start);
        part_size    <= ADDR_W'(cur.len);
        is_allocated <= cur.busy;
        owner_job    <= JOB_W'(cur.owner);
        requested    <= cur.req;
      end else begin
        address      <= '0;
        part_size    <= '0;
        is_allocated <= 1'b0;
        owner_job    <= '0;
        requested    <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNTW'(N))
    else $error("entry count beyond table size");
  a_no_grow_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !stat.full)
    else $error("table grows while full");
  a_shrink: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |=> count == $past(count) - CNTW'(1))
    else $error("entry count did not drop by one");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result overwrites one not yet taken");

endmodule

FILE: rtl/bfpa_ctrl.sv
`timescale 1ns / 1ps
module bfpa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  bfpa_pkg::op_t   req_op,
  output logic            req_ready,
  input  bfpa_pkg::stat_t stat,
  output bfpa_pkg::cmd_t  cmd
);
  import bfpa_pkg::*;

  state_t  state;
  state_t  state_next;
  status_t res;
  status_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= ST_OK;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load      = 1'b1;
          cmd.ptr_op    = PTR_ZERO;
          cmd.found_clr = 1'b1;
          unique case (req_op)
            OP_APPEND:  state_next = S_APP;
            OP_ALLOC:   state_next = S_AL_START;
            OP_RELEASE: state_next = S_RL_SCAN;
            OP_READ:    state_next = S_RD_START;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_APP: begin
        state_next = S_FIN;
        priority if (stat.amt_zero) begin
          res_next = ST_NO_FIT;
        end else if (stat.full) begin
          res_next = ST_FULL;
        end else if (stat.overflow) begin
          res_next = ST_OVERFLOW;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wa_sel  = WA_CNT;
          cmd.wd_sel  = WD_APPEND;
          cmd.cur_op  = CUR_APPEND;
          cmd.cnt_inc = 1'b1;
          cmd.end_adv = 1'b1;
          res_next    = ST_OK;
        end
      end
      S_RD_START: begin
        if (stat.idx_bad) begin
          res_next   = ST_NO_FIT;
          state_next = S_FIN;
        end else begin
          cmd.ptr_op = PTR_IDX;
          state_next = S_RD_MEM;
        end
      end
      S_RD_MEM: state_next = S_RD_USE;
      S_RD_USE: begin
        cmd.cur_op = CUR_RDATA;
        res_next   = ST_OK;
        state_next = S_FIN;
      end
      S_AL_START: begin
        if (stat.amt_zero) begin
          res_next   = ST_NO_FIT;
          state_next = S_FIN;
        end else begin
          state_next = S_AL_SCAN;
        end
      end
      S_AL_SCAN: begin
        state_next = stat.ptr_at_cnt ? S_AL_DECIDE : S_AL_USE;
      end
      S_AL_USE: begin
        if (stat.cand) begin
          cmd.cur_op    = CUR_RDATA;
          cmd.pos_op    = POS_PTR;
          cmd.found_set = 1'b1;
        end
        cmd.ptr_op = PTR_INC;
        state_next = S_AL_SCAN;
      end
      S_AL_DECIDE: begin
        priority if (!stat.found) begin
          res_next   = ST_NO_FIT;
          state_next = S_FIN;
        end else if (stat.exact) begin
          cmd.wr_en  = 1'b1;
          cmd.wa_sel = WA_POS;
          cmd.wd_sel = WD_FRONT;
          cmd.cur_op = CUR_FRONT;
          res_next   = ST_OK;
          state_next = S_FIN;
        end else if (stat.full) begin
          res_next   = ST_FULL;
          state_next = S_FIN;
        end else begin
          cmd.ptr_op = PTR_CNT_M1;
          state_next = S_AL_SHCHK;
        end
      end
      // open a slot after the best entry, moving the tail up from the top
      S_AL_SHCHK: begin
        state_next = stat.ptr_at_pos ? S_AL_REM : S_AL_SHUSE;
      end
      S_AL_SHUSE: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_PTR_P1;
        cmd.wd_sel = WD_COPY;
        cmd.ptr_op = PTR_DEC;
        state_next = S_AL_SHCHK;
      end
      S_AL_REM: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_POS_P1;
        cmd.wd_sel = WD_REMAIN;
        state_next = S_AL_FRONT;
      end
      S_AL_FRONT: begin
        cmd.wr_en   = 1'b1;
        cmd.wa_sel  = WA_POS;
        cmd.wd_sel  = WD_FRONT;
        cmd.cur_op  = CUR_FRONT;
        cmd.cnt_inc = 1'b1;
        res_next    = ST_OK;
        state_next  = S_FIN;
      end
      S_RL_SCAN: begin
        if (stat.ptr_at_cnt) begin
          res_next   = ST_NOT_FOUND;
          state_next = S_FIN;
        end else begin
          state_next = S_RL_USE;
        end
      end
      S_RL_USE: begin
        if (stat.match) begin
          cmd.cur_op = CUR_RDATA;
          cmd.pos_op = POS_PTR;
          state_next = S_RL_NXT;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_next = S_RL_SCAN;
        end
      end
      S_RL_NXT: begin
        if (stat.pos_last) begin
          state_next = S_RL_PRV;
        end else begin
          cmd.ptr_op = PTR_POS_P1;
          state_next = S_RL_NMEM;
        end
      end
      S_RL_NMEM: state_next = S_RL_NUSE;
      S_RL_NUSE: begin
        if (stat.adj_next) begin
          cmd.cur_op = CUR_ADD_NEXT;
          cmd.ptr_op = PTR_INC;
          state_next = S_RL_D1CHK;
        end else begin
          state_next = S_RL_PRV;
        end
      end
      // drop the absorbed entry: pull the tail down by one place
      S_RL_D1CHK: begin
        if (stat.ptr_at_cnt) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_RL_PRV;
        end else begin
          state_next = S_RL_D1USE;
        end
      end
      S_RL_D1USE: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_PTR_M1;
        cmd.wd_sel = WD_COPY;
        cmd.ptr_op = PTR_INC;
        state_next = S_RL_D1CHK;
      end
      S_RL_PRV: begin
        if (stat.pos_zero) begin
          state_next = S_RL_WR;
        end else begin
          cmd.ptr_op = PTR_POS_M1;
          state_next = S_RL_PMEM;
        end
      end
      S_RL_PMEM: state_next = S_RL_PUSE;
      S_RL_PUSE: begin
        if (stat.adj_prev) begin
          cmd.cur_op = CUR_ADD_PREV;
          cmd.ptr_op = PTR_POS_P1;
          cmd.pos_op = POS_DEC;
          state_next = S_RL_D2CHK;
        end else begin
          state_next = S_RL_WR;
        end
      end
      S_RL_D2CHK: begin
        if (stat.ptr_at_cnt) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_RL_WR;
        end else begin
          state_next = S_RL_D2USE;
        end
      end
      S_RL_D2USE: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_PTR_M1;
        cmd.wd_sel = WD_COPY;
        cmd.ptr_op = PTR_INC;
        state_next = S_RL_D2CHK;
      end
      S_RL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_POS;
        cmd.wd_sel = WD_FREE;
        cmd.cur_op = CUR_FREE;
        res_next   = ST_OK;
        state_next = S_FIN;
      end
      // hold until the output register can take the result
      S_FIN: begin
        cmd.out_status = res;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/best_fit_partition_allocator_top.sv
`timescale 1ns / 1ps
// Best-fit partition allocator. The partition table lives in a memory with a
// write port and a registered read port, and a controller walks it one entry
// at a time, so cost grows with the table fill n. Append checks the amount, the
// fill and the address space and writes at the end; read checks the index, then
// reads that entry. Allocate scans every entry for the search (a zero amount is
// refused at once), and a split moves each later entry up one place, then writes
// the remainder and the front part. Release scans for the job's entry, checks
// the next and the previous neighbor, and for each merge pulls every later
// entry down one place. One item is in work at a time; the result sits in an
// output register, and the next item is taken once the result is loaded there.
module best_fit_partition_allocator_top #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ADDRESS_BITS  = 16,
  parameter int JOB_BITS      = 8
) (
  input logic         clk,
  input logic         rst,
  bfpa_req_if.sink    req,
  bfpa_rsp_if.source  rsp
);
  import bfpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (op_t'(req.operation)),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bfpa_dpath #(
    .N  (TABLE_ENTRIES),
    .AW (ADDRESS_BITS),
    .JB (JOB_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .job_id       (req.job_id),
    .amount       (req.amount),
    .entry_index  (req.entry_index),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .status       (rsp.status),
    .address      (rsp.address),
    .part_size    (rsp.part_size),
    .is_allocated (rsp.is_allocated),
    .owner_job    (rsp.owner_job),
    .requested    (rsp.requested),
    .entry_total  (rsp.entry_total)
  );

endmodule

FILE: bench/tb_best_fit_partition_allocator_top.sv
`timescale 1ns / 1ps
module tb_best_fit_partition_allocator_top;
  import bfpa_pkg::*;

  localparam int NPART = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] address;
    logic [15:0] part_size;
    logic        is_allocated;
    logic [7:0]  owner_job;
    logic [15:0] requested;
    logic [4:0]  entry_total;
  } alloc_reply_t;

  class alloc_scoreboard;
    logic [15:0] p_start [NPART];
    logic [15:0] p_len [NPART];
    logic        p_busy [NPART];
    logic [7:0]  p_owner [NPART];
    logic [15:0] p_req [NPART];
    int          count;
    logic [15:0] end_addr;
    alloc_reply_t pending[$];
    int          errors;

    function void clear();
      count = 0;
      end_addr = '0;
      errors = 0;
      pending.delete();
    endfunction

    function void move_slot(int dst, int src);
      p_start[dst] = p_start[src];
      p_len[dst] = p_len[src];
      p_busy[dst] = p_busy[src];
      p_owner[dst] = p_owner[src];
      p_req[dst] = p_req[src];
    endfunction

    function void drop_slot(int pos);
      for (int i = pos; i + 1 < count; i++) move_slot(i, i + 1);
      count--;
    endfunction

    function void fill(ref alloc_reply_t r, input int i);
      r.address = p_start[i];
      r.part_size = p_len[i];
      r.is_allocated = p_busy[i];
      r.owner_job = p_owner[i];
      r.requested = p_req[i];
    endfunction

    function void note_request(op_t op, logic [7:0] job, logic [15:0] amt, logic [3:0] idx);
      alloc_reply_t r;
      bit found;
      int best;
      int pos;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_APPEND: begin
          if (amt == 0) r.status = ST_NO_FIT;
          else if (count >= NPART) r.status = ST_FULL;
          else if ({1'b0, end_addr} + amt > 17'h0FFFF) r.status = ST_OVERFLOW;
          else begin
            p_start[count] = end_addr;
            p_len[count] = amt;
            p_busy[count] = 0;
            p_owner[count] = 0;
            p_req[count] = 0;
            end_addr = end_addr + amt;
            fill(r, count);
            count++;
          end
        end
        OP_ALLOC: begin
          found = 0;
          best = 0;
          if (amt != 0)
            for (int i = 0; i < count; i++)
              if (!p_busy[i] && p_len[i] >= amt && (!found || p_len[i] < p_len[best])) begin
                found = 1;
                best = i;
              end
          if (!found) r.status = ST_NO_FIT;
          else if (p_len[best] == amt) begin
            p_busy[best] = 1;
            p_owner[best] = job;
            p_req[best] = amt;
            fill(r, best);
          end else if (count >= NPART) r.status = ST_FULL;
          else begin
            for (int i = count; i > best; i--) move_slot(i, i - 1);
            count++;
            p_len[best] = amt;
            p_busy[best] = 1;
            p_owner[best] = job;
            p_req[best] = amt;
            p_start[best + 1] = p_start[best] + amt;
            p_len[best + 1] = p_len[best + 1] - amt;
            p_busy[best + 1] = 0;
            p_owner[best + 1] = 0;
            p_req[best + 1] = 0;
            fill(r, best);
          end
        end
        OP_RELEASE: begin
          pos = -1;
          for (int i = 0; i < count; i++)
            if (pos < 0 && p_busy[i] && p_owner[i] == job) pos = i;
          if (pos < 0) r.status = ST_NOT_FOUND;
          else begin
            p_busy[pos] = 0;
            p_owner[pos] = 0;
            p_req[pos] = 0;
            if (pos + 1 < count && !p_busy[pos + 1] &&
                16'(p_start[pos] + p_len[pos]) == p_start[pos + 1]) begin
              p_len[pos] = p_len[pos] + p_len[pos + 1];
              drop_slot(pos + 1);
            end
            if (pos > 0 && !p_busy[pos - 1] &&
                16'(p_start[pos - 1] + p_len[pos - 1]) == p_start[pos]) begin
              p_len[pos - 1] = p_len[pos - 1] + p_len[pos];
              drop_slot(pos);
              pos--;
            end
            fill(r, pos);
          end
        end
        default: begin
          if (idx >= count) r.status = ST_NO_FIT;
          else fill(r, idx);
        end
      endcase
      r.entry_total = count[4:0];
      pending.push_back(r);
    endfunction

    function void check_reply(alloc_reply_t got);
      alloc_reply_t exp;
      if (pending.size() == 0) begin
        $display("%0t unexpected reply %h", $realtime, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        $display("%0t status exp %0d got %0d", $realtime, exp.status, got.status);
      if (got.address !== exp.address)
        $display("%0t address exp %h got %h", $realtime, exp.address, got.address);
      if (got.part_size !== exp.part_size)
        $display("%0t part_size exp %h got %h", $realtime, exp.part_size, got.part_size);
      if (got.is_allocated !== exp.is_allocated)
        $display("%0t is_allocated exp %b got %b", $realtime, exp.is_allocated,
                 got.is_allocated);
      if (got.owner_job !== exp.owner_job)
        $display("%0t owner_job exp %h got %h", $realtime, exp.owner_job, got.owner_job);
      if (got.requested !== exp.requested)
        $display("%0t requested exp %h got %h", $realtime, exp.requested, got.requested);
      if (got.entry_total !== exp.entry_total)
        $display("%0t entry_total exp %0d got %0d", $realtime, exp.entry_total,
                 got.entry_total);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  int   send_idle_pct = 18;
  int   recv_idle_pct = 65;
  int   quiet_cycles = 0;
  alloc_scoreboard board;

  bfpa_req_if req ();
  bfpa_rsp_if rsp ();

  best_fit_partition_allocator_top u_top (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #10 clk = ~clk;

  initial begin
    req.valid = 0;
    req.operation = OP_READ;
    req.job_id = '0;
    req.amount = '0;
    req.entry_index = '0;
    rsp.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready)
        board.check_reply({rsp.status, rsp.address, rsp.part_size, rsp.is_allocated,
                           rsp.owner_job, rsp.requested, rsp.entry_total});
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_op(op_t op, logic [7:0] job, logic [15:0] amt, logic [3:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid <= 1;
    req.operation <= op;
    req.job_id <= job;
    req.amount <= amt;
    req.entry_index <= idx;
    do @(posedge clk); while (!req.ready);
    board.note_request(op, job, amt, idx);
  endtask

  // mostly well-formed traffic: small sizes, few jobs so releases hit
  task automatic random_op();
    int sel;
    logic [15:0] amt;
    sel = $urandom_range(99);
    amt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 600));
    if ($urandom_range(29) == 0) amt = 0;
    if (sel < 20)
      send_op(OP_APPEND, 8'($urandom), amt, 4'($urandom));
    else if (sel < 55)
      send_op(OP_ALLOC, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
              amt, 4'($urandom));
    else if (sel < 80)
      send_op(OP_RELEASE, ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
              16'($urandom), 4'($urandom));
    else
      send_op(OP_READ, 8'($urandom), 16'($urandom), 4'($urandom));
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_op(OP_READ, 8'hFF, 16'hFFFF, 4'd0);
    send_op(OP_ALLOC, 8'd1, 16'd10, 4'd0);
    send_op(OP_RELEASE, 8'd1, 16'd0, 4'd0);
    send_op(OP_APPEND, 8'd0, 16'd0, 4'd0);
    send_op(OP_APPEND, 8'd0, 16'd100, 4'd0);
    send_op(OP_APPEND, 8'd0, 16'd50, 4'd0);
    send_op(OP_APPEND, 8'd0, 16'd100, 4'd0);
    send_op(OP_ALLOC, 8'd2, 16'd50, 4'd0);
    send_op(OP_ALLOC, 8'hFF, 16'd30, 4'd0);
    send_op(OP_ALLOC, 8'd3, 16'd0, 4'd0);
    send_op(OP_ALLOC, 8'd4, 16'hFFFF, 4'd0);
    send_op(OP_READ, 8'd0, 16'd0, 4'd1);
    send_op(OP_READ, 8'd0, 16'd0, 4'hF);
    send_op(OP_RELEASE, 8'hFF, 16'd0, 4'd0);
    send_op(OP_RELEASE, 8'd2, 16'd0, 4'd0);
    send_op(OP_RELEASE, 8'd9, 16'd0, 4'd0);
    send_op(OP_APPEND, 8'd0, 16'hFFFF, 4'd0);
    send_op(OP_APPEND, 8'd0, 16'hFEB0, 4'd0);
    for (int i = 0; i < 14; i++) send_op(OP_ALLOC, 8'(i), 16'd1, 4'd0);
    send_op(OP_READ, 8'd0, 16'd0, 4'hF);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 65 : 0;
      recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 18 : 0;
      for (int n = 0; n < 540; n++) begin
        random_op();
      end
    end
    req.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: best_fit_partition_allocator_top.f
rtl/bfpa_pkg.sv
rtl/bfpa_req_if.sv
rtl/bfpa_rsp_if.sv
rtl/bfpa_dpath.sv
rtl/bfpa_ctrl.sv
rtl/best_fit_partition_allocator_top.sv
bench/tb_best_fit_partition_allocator_top.sv
